// ===== rtl/tspsr_pkg.sv =====
`default_nettype none
package tspsr_pkg;
  localparam int STORE_DEPTH = 8192;
  localparam int AW = $clog2(STORE_DEPTH);
  localparam int CW = AW + 1;
  localparam int PAYLOAD_BYTES = 184;
  localparam int MAX_SECTIONS = 64;
  localparam logic [7:0] FILLER_ID = 8'hFF;
  localparam logic [1:0] FUNC_BYTE = 2'd0;
  localparam logic [1:0] FUNC_READ = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;
  typedef logic [AW-1:0] addr_t;
  typedef logic [CW-1:0] cnt_t;
endpackage
`default_nettype wire

// ===== rtl/tspsr_ram.sv =====
`default_nettype none
module tspsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  wire                     clk,
  input  wire                     we,
  input  wire [$clog2(DEPTH)-1:0] waddr,
  input  wire [WIDTH-1:0]         wdata,
  input  wire [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]        rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/ts_psi_section_reassembler.sv =====
// A payload byte, clear or unused code is taken while idle; a read registers its address, then
// waits on the registered store read and loads the output register before the next item.
// Throughput: one payload byte per cycle while idle and the output is not stalled; after a
// last-of-packet byte the input stalls while sections are parsed: per complete section the
// table id, then both length bytes are read one at a time from the store, a 0xFF filler id
// adds a jump to the restart point, and the parse stops on an unfinished section.
// Reset: synchronous; clears base, fill, restart, packet counters, out_valid; store undefined.
`default_nettype none
module ts_psi_section_reassembler (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [1:0]  func,
  input  wire  [7:0]  data_byte,
  input  wire         unit_start,
  input  wire         has_adaptation,
  input  wire         first_of_packet,
  input  wire         last_of_packet,
  input  wire  [12:0] read_address,
  output logic        out_valid,
  input  wire         out_stall,
  output logic        kind,
  output logic [7:0]  sect_id,
  output logic [12:0] section_start,
  output logic [11:0] sect_len,
  output logic        overrun,
  output logic [7:0]  read_data,
  output logic        last
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RDW  = 4'd1;
  localparam logic [3:0] S_RDD  = 4'd2;
  localparam logic [3:0] S_X0   = 4'd3;
  localparam logic [3:0] S_X0W  = 4'd4;
  localparam logic [3:0] S_X0D  = 4'd5;
  localparam logic [3:0] S_XFW  = 4'd6;
  localparam logic [3:0] S_XFD  = 4'd7;
  localparam logic [3:0] S_L1W  = 4'd8;
  localparam logic [3:0] S_L1D  = 4'd9;
  localparam logic [3:0] S_L2D  = 4'd10;
  localparam logic [3:0] S_EMIT = 4'd11;
  localparam logic [3:0] S_WAIT = 4'd12;

  logic [3:0] state;
  tspsr_pkg::addr_t base;
  tspsr_pkg::cnt_t fill, restart, off, saved;
  logic [7:0] pidx, skip;
  logic dropped, pending;
  logic [6:0] nsec;
  logic [7:0] tid;
  logic [3:0] lenhi;
  logic [11:0] len;

  // section result held back until it is known whether it is the last one
  logic hold_valid;
  logic [7:0] hold_id;
  logic [12:0] hold_start;
  logic [11:0] hold_len;
  logic hold_ovr;

  // store port signals
  logic we;
  tspsr_pkg::addr_t waddr, raddr, rsel;
  logic [7:0] rdata;
  logic [7:0] wbyte;

  tspsr_ram #(.WIDTH(8), .DEPTH(tspsr_pkg::STORE_DEPTH)) u_store (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wbyte), .raddr(raddr), .rdata(rdata)
  );

  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);
  wire acc = in_valid && !in_stall;
  wire out_free = !out_valid || !out_stall;

  // byte path decode (combinational, used at accept)
  logic [7:0] pidx0, skip0, skip_next;
  logic dropped0, pending0, pend_next, drop_next;
  logic app, app_ok, opened, restart_load;
  tspsr_pkg::cnt_t restart_val;
  always_comb begin
    pidx0 = first_of_packet ? 8'd0 : pidx;
    skip0 = first_of_packet ? 8'd0 : skip;
    dropped0 = first_of_packet ? 1'b0 : dropped;
    pending0 = first_of_packet ? 1'b0 : pending;
    pend_next = pending0;
    drop_next = dropped0;
    skip_next = skip0;
    app = 1'b0;
    opened = 1'b0;
    restart_load = 1'b0;
    restart_val = fill + tspsr_pkg::cnt_t'(data_byte);
    if (pidx0 < 8'(tspsr_pkg::PAYLOAD_BYTES) && !dropped0) begin
      // first byte: open the payload, take an adaptation length
      if (pidx0 == 8'd0) begin
        pend_next = 1'b1;
        if (has_adaptation) begin
          opened = 1'b1;
          if (data_byte >= 8'(tspsr_pkg::PAYLOAD_BYTES - 1)) drop_next = 1'b1;
          else skip_next = data_byte;
        end
      end
      if (!opened) begin
        if (skip_next != 8'd0) skip_next = skip_next - 8'd1;
        else if (pend_next) begin
          pend_next = 1'b0;
          if (unit_start) begin
            restart_load = 1'b1;
            if (fill == '0) begin
              restart_val = '0;
              if (data_byte > 8'(tspsr_pkg::PAYLOAD_BYTES - 1) - pidx0) drop_next = 1'b1;
              else skip_next = data_byte;
            end
          end else if (fill == '0) drop_next = 1'b1;
          else app = 1'b1;
        end else app = 1'b1;
      end
    end
    app_ok = app && (fill != tspsr_pkg::cnt_t'(tspsr_pkg::STORE_DEPTH));
  end

  tspsr_pkg::cnt_t end_off;
  logic sec_ovr;
  assign end_off = off + tspsr_pkg::cnt_t'(3) + tspsr_pkg::cnt_t'(len);
  assign rsel = base + off[tspsr_pkg::AW-1:0];
  assign sec_ovr = (end_off != fill) && (restart != '0) && (end_off > restart);

  // output loads: read data, an earlier section, or the final section of a parse
  logic pub_read, pub_sec, pub_last;
  assign pub_read = (state == S_RDD) && out_free;
  assign pub_sec = (state == S_EMIT) && !(end_off > fill) && hold_valid && out_free;
  assign pub_last = (state == S_WAIT) && hold_valid && out_free;

  // append an accepted payload byte in the cycle after it is accepted
  always_ff @(posedge clk) begin
    we <= !rst && acc && (func == tspsr_pkg::FUNC_BYTE) && app_ok;
    waddr <= base + fill[tspsr_pkg::AW-1:0];
    wbyte <= data_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; base <= '0; fill <= '0; restart <= '0;
      pidx <= '0; skip <= '0; dropped <= 1'b0; pending <= 1'b0;
      hold_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (acc) begin
          if (func == tspsr_pkg::FUNC_READ) begin
            raddr <= read_address[tspsr_pkg::AW-1:0];
            state <= S_RDW;
          end else if (func == tspsr_pkg::FUNC_CLEAR) begin
            fill <= '0; restart <= '0; pidx <= '0; skip <= '0;
            dropped <= 1'b0; pending <= 1'b0;
          end else if (func == tspsr_pkg::FUNC_BYTE) begin
            if (app_ok) fill <= fill + tspsr_pkg::cnt_t'(1);
            if (restart_load) restart <= restart_val;
            if (last_of_packet) begin
              pidx <= '0; skip <= '0; dropped <= 1'b0; pending <= 1'b0;
              nsec <= '0;
              state <= S_X0;
            end else begin
              pidx <= (pidx0 != 8'd255) ? pidx0 + 8'd1 : pidx0;
              skip <= skip_next; dropped <= drop_next; pending <= pend_next;
            end
          end
        end
        S_RDW: state <= S_RDD;
        S_RDD: if (out_free) state <= S_IDLE;
        // start one section: read table id at offset 0, or end the parse at the section limit or empty store
        S_X0: begin
          if (nsec == 7'(tspsr_pkg::MAX_SECTIONS) || fill == '0) begin
            state <= S_WAIT;
          end else begin
            off <= '0; saved <= restart;
            raddr <= base;
            state <= S_X0W;
          end
        end
        S_X0W: state <= S_X0D;
        S_X0D: begin
          if (rdata == tspsr_pkg::FILLER_ID) begin
            if (restart >= fill) state <= S_WAIT;
            else begin
              off <= restart; restart <= '0;
              raddr <= base + restart[tspsr_pkg::AW-1:0];
              state <= S_XFW;
            end
          end else begin
            tid <= rdata;
            if (tspsr_pkg::cnt_t'(3) > fill) state <= S_WAIT;
            else begin
              raddr <= base + tspsr_pkg::addr_t'(1);
              state <= S_L1W;
            end
          end
        end
        S_XFW: state <= S_XFD;
        S_XFD: begin
          if (rdata == tspsr_pkg::FILLER_ID) begin
            fill <= '0; state <= S_WAIT;
          end else begin
            tid <= rdata;
            if (off + tspsr_pkg::cnt_t'(3) > fill) begin
              restart <= saved; state <= S_WAIT;
            end else begin
              raddr <= rsel + tspsr_pkg::addr_t'(1);
              state <= S_L1W;
            end
          end
        end
        S_L1W: begin
          raddr <= rsel + tspsr_pkg::addr_t'(2);
          state <= S_L1D;
        end
        S_L1D: begin lenhi <= rdata[3:0]; state <= S_L2D; end
        S_L2D: begin len <= {lenhi, rdata}; state <= S_EMIT; end
        // hold the found section and release its bytes, or end the parse if it is not yet complete
        S_EMIT: begin
          if (end_off > fill) begin
            restart <= saved;
            state <= S_WAIT;
          end else if (!hold_valid || out_free) begin
            hold_valid <= 1'b1; hold_id <= tid; hold_start <= rsel;
            hold_len <= len; hold_ovr <= sec_ovr;
            if (end_off == fill) fill <= '0;
            else begin
              fill <= fill - end_off;
              base <= base + end_off[tspsr_pkg::AW-1:0];
              if (restart != '0) restart <= sec_ovr ? '0 : restart - end_off;
            end
            nsec <= nsec + 7'd1;
            state <= S_X0;
          end
        end
        // flush the held section as the last result
        S_WAIT: begin
          if (!hold_valid) state <= S_IDLE;
          else if (out_free) begin
            hold_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (pub_read || pub_sec || pub_last) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
    if (pub_read) begin
      kind <= 1'b1; sect_id <= '0; section_start <= '0; sect_len <= '0;
      overrun <= 1'b0; read_data <= rdata; last <= 1'b1;
    end else if (pub_sec || pub_last) begin
      kind <= 1'b0; sect_id <= hold_id; section_start <= hold_start; sect_len <= hold_len;
      overrun <= hold_ovr; read_data <= '0; last <= pub_last;
    end
  end
endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
module testbench;
  localparam logic [1:0] FUNC_NONE = 2'd3;
  localparam int CYCLE_LIMIT = 800000;
  localparam int PHASE_ITEMS = 52;

  typedef struct {
    logic [1:0]  func;
    logic [7:0]  data;
    logic        unit_start;
    logic        has_adapt;
    logic        first;
    logic        last;
    logic [12:0] addr;
  } ts_byte_t;

  typedef struct {
    logic        kind;
    logic [7:0]  sect_id;
    logic [12:0] start;
    logic [11:0] length;
    logic        overrun;
    logic [7:0]  read_data;
    logic        last;
  } section_rpt_t;

  // one row of the directed table; a typed report replaces the predicted one
  typedef struct {
    ts_byte_t     stim;
    bit           typed;
    section_rpt_t rpt;
  } directed_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  func = tspsr_pkg::FUNC_BYTE;
  logic [7:0]  data_byte = '0;
  logic        unit_start = 1'b0;
  logic        has_adaptation = 1'b0;
  logic        first_of_packet = 1'b0;
  logic        last_of_packet = 1'b0;
  logic [12:0] read_address = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        kind;
  logic [7:0]  sect_id;
  logic [12:0] section_start;
  logic [11:0] sect_len;
  logic        overrun;
  logic [7:0]  read_data;
  logic        last;

  ts_psi_section_reassembler dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .func(func), .data_byte(data_byte), .unit_start(unit_start),
    .has_adaptation(has_adaptation), .first_of_packet(first_of_packet),
    .last_of_packet(last_of_packet), .read_address(read_address),
    .out_valid(out_valid), .out_stall(out_stall),
    .kind(kind), .sect_id(sect_id), .section_start(section_start),
    .sect_len(sect_len), .overrun(overrun),
    .read_data(read_data), .last(last)
  );

  always #6 clk = ~clk;

  // shadow state of the reassembler
  logic [7:0]  ring [tspsr_pkg::STORE_DEPTH];
  bit          ring_written [tspsr_pkg::STORE_DEPTH];
  int unsigned ring_base, held, restart_at, consumed;
  int unsigned pkt_index, skip_left;
  bit          pkt_dropped, payload_open;
  int          last_written_addr = -1;

  section_rpt_t expected_reports[$];
  int           failures = 0;
  int           bytes_sent = 0, reports_seen = 0, sections_seen = 0;
  int           tx_idle_pct = 0, rx_idle_pct = 0;
  int unsigned  cycle_count = 0;

  function automatic logic [7:0] ring_peek(int unsigned off);
    return ring[(ring_base + off) % tspsr_pkg::STORE_DEPTH];
  endfunction

  function automatic void ring_append(logic [7:0] b);
    int unsigned idx;
    if (held < tspsr_pkg::STORE_DEPTH) begin
      idx = (ring_base + held) % tspsr_pkg::STORE_DEPTH;
      ring[idx] = b;
      ring_written[idx] = 1'b1;
      last_written_addr = idx;
      held++;
    end
  endfunction

  function automatic void ring_release();
    ring_base = (ring_base + consumed) % tspsr_pkg::STORE_DEPTH;
    consumed = 0;
  endfunction

  function automatic void packet_reset();
    pkt_index = 0;
    skip_left = 0;
    pkt_dropped = 1'b0;
    payload_open = 1'b0;
  endfunction

  function automatic section_rpt_t section_rpt(logic [7:0] tid, int unsigned st,
                                               int unsigned len, bit ovr);
    section_rpt_t r;
    r = '{kind: 1'b0, sect_id: tid, start: st[12:0], length: len[11:0],
          overrun: ovr, read_data: 8'h00, last: 1'b0};
    return r;
  endfunction

  // pull complete sections out of the ring at a packet end
  function automatic void extract_sections();
    int unsigned n, off, saved, len, fin;
    bit ovr, stop;
    logic [7:0] tid;
    section_rpt_t tail;
    n = 0;
    stop = 1'b0;
    while (!stop && n < tspsr_pkg::MAX_SECTIONS && held != 0) begin
      off = 0;
      saved = restart_at;
      ovr = 1'b0;
      ring_release();
      tid = ring_peek(0);
      if (tid == tspsr_pkg::FILLER_ID) begin
        off = restart_at;
        restart_at = 0;
        if (off >= held) begin
          restart_at = saved;
          stop = 1'b1;
        end else begin
          tid = ring_peek(off);
          if (tid == tspsr_pkg::FILLER_ID) begin
            held = 0;
            stop = 1'b1;
          end
        end
      end
      if (!stop && off + 3 > held) begin
        restart_at = saved;
        stop = 1'b1;
      end
      if (!stop) begin
        len = {ring_peek(off + 1) & 8'h0F, ring_peek(off + 2)};
        fin = off + 3 + len;
        if (fin > held) begin
          restart_at = saved;
          stop = 1'b1;
        end else begin
          if (fin == held) begin
            held = 0;
          end else begin
            consumed = fin;
            held -= fin;
            if (restart_at > 0) begin
              if (fin > restart_at) begin
                ovr = 1'b1;
                restart_at = 0;
              end else begin
                restart_at -= fin;
              end
            end
          end
          expected_reports.push_back(section_rpt(tid,
                                                 (ring_base + off) % tspsr_pkg::STORE_DEPTH,
                                                 len, ovr));
          n++;
        end
      end
    end
    ring_release();
    if (n > 0) begin
      tail = expected_reports.pop_back();
      tail.last = 1'b1;
      expected_reports.push_back(tail);
    end
  endfunction

  function automatic void open_payload(logic [7:0] b, logic us);
    payload_open = 1'b0;
    if (us) begin
      if (held != 0) begin
        restart_at = held + b;
      end else begin
        restart_at = 0;
        if (b > (tspsr_pkg::PAYLOAD_BYTES - 1) - pkt_index) pkt_dropped = 1'b1;
        else skip_left = b;
      end
    end else if (held == 0) begin
      pkt_dropped = 1'b1;
    end else begin
      ring_append(b);
    end
  endfunction

  // advance the shadow state by one accepted item
  function automatic void predict_item(ts_byte_t it);
    section_rpt_t r;
    bit consumed_here;
    case (it.func)
      tspsr_pkg::FUNC_READ: begin
        r = '{kind: 1'b1, sect_id: 8'h00, start: '0, length: '0, overrun: 1'b0,
              read_data: ring[it.addr], last: 1'b1};
        expected_reports.push_back(r);
      end
      tspsr_pkg::FUNC_CLEAR: begin
        held = 0;
        restart_at = 0;
        consumed = 0;
        packet_reset();
      end
      tspsr_pkg::FUNC_BYTE: begin
        if (it.first) packet_reset();
        if (pkt_index < tspsr_pkg::PAYLOAD_BYTES && !pkt_dropped) begin
          consumed_here = 1'b0;
          if (pkt_index == 0) begin
            payload_open = 1'b1;
            if (it.has_adapt) begin
              consumed_here = 1'b1;
              if (it.data >= tspsr_pkg::PAYLOAD_BYTES - 1) pkt_dropped = 1'b1;
              else skip_left = it.data;
            end
          end
          if (!consumed_here) begin
            if (skip_left > 0) skip_left--;
            else if (payload_open) open_payload(it.data, it.unit_start);
            else ring_append(it.data);
          end
        end
        if (pkt_index < 255) pkt_index++;
        if (it.last) begin
          packet_reset();
          extract_sections();
        end
      end
      default: ;
    endcase
  endfunction

  // drive one item and hold it until accepted
  task automatic send_item(ts_byte_t it, bit typed = 1'b0,
                           section_rpt_t rpt = '{default: '0});
    // never read a ring entry that was never written
    if (it.func == tspsr_pkg::FUNC_READ && !ring_written[it.addr]) begin
      if (last_written_addr < 0) it.func = FUNC_NONE;
      else it.addr = last_written_addr[12:0];
    end
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    func = it.func;
    data_byte = it.data;
    unit_start = it.unit_start;
    has_adaptation = it.has_adapt;
    first_of_packet = it.first;
    last_of_packet = it.last;
    read_address = it.addr;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_item(it);
    if (typed) expected_reports[$] = rpt;
    bytes_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  function automatic ts_byte_t mk(logic [1:0] f, logic [7:0] d, logic us = 0, logic ha = 0,
                                  logic fp = 0, logic lp = 0, logic [12:0] ra = 0);
    ts_byte_t it;
    it = '{func: f, data: d, unit_start: us, has_adapt: ha, first: fp, last: lp, addr: ra};
    return it;
  endfunction

  // emit a burst of sections split over short packets
  task automatic send_burst();
    logic [7:0] stream[$];
    ts_byte_t   it;
    int         nsec, len, plen, k;
    bit         starting;
    nsec = $urandom_range(1, 3);
    for (int s = 0; s < nsec; s++) begin
      stream.push_back($urandom_range(9) == 0 ? tspsr_pkg::FILLER_ID
                                               : 8'($urandom_range(254)));
      len = ($urandom_range(19) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 8);
      stream.push_back({4'($urandom), 4'(len >> 8)});
      stream.push_back(8'(len));
      for (int j = 0; j < len; j++) stream.push_back(8'($urandom));
    end
    if ($urandom_range(4) == 0) stream.push_back(tspsr_pkg::FILLER_ID);
    starting = 1'b1;
    while (stream.size() > 0) begin
      plen = $urandom_range(3, 40);
      k = 0;
      // drop one to eight stream bytes now and then to break the sequence
      if (!starting && $urandom_range(11) == 0) begin
        repeat ($urandom_range(1, 8)) if (stream.size() > 0) void'(stream.pop_front());
        continue;
      end
      if ($urandom_range(6) == 0) begin
        send_item(mk(tspsr_pkg::FUNC_BYTE, 8'($urandom_range(0, 3)), 0, 1, 1, 0,
                     13'($urandom)));
        k++;
        repeat ($urandom_range(0, 3)) begin
          send_item(mk(tspsr_pkg::FUNC_BYTE, 8'($urandom), 0, 0, 0, 0, 13'($urandom)));
          k++;
        end
      end
      while (k < plen && stream.size() > 0) begin
        it = mk(tspsr_pkg::FUNC_BYTE, 8'h00, 0, 0, k == 0, 0, 13'($urandom));
        if (starting) begin
          it.unit_start = 1'b1;
          starting = 1'b0;
        end else begin
          it.data = stream.pop_front();
        end
        it.last = (k == plen - 1) || (stream.size() == 0);
        send_item(it);
        k++;
      end
    end
  endtask

  task automatic send_noise();
    send_item(mk(2'($urandom), 8'($urandom), 1'($urandom), 1'($urandom),
                 1'($urandom), 1'($urandom), 13'($urandom)));
  endtask

  task automatic run_phase(int tx_pct, int rx_pct, int item_goal);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    while (bytes_sent < item_goal) begin
      send_burst();
      if ($urandom_range(4) == 0) send_noise();
      if ($urandom_range(2) == 0)
        send_item(mk(tspsr_pkg::FUNC_READ, 8'($urandom), 0, 0, 0, 0, 13'($urandom)));
      if ($urandom_range(24) == 0) send_item(mk(tspsr_pkg::FUNC_CLEAR, 8'($urandom)));
    end
  endtask

  function automatic void check_field(string name, logic [12:0] want, logic [12:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      failures++;
    end
  endfunction

  // receiver back-pressure
  always @(negedge clk) out_stall <= ($urandom_range(99) < rx_idle_pct);

  // compare each accepted report with the oldest expectation
  always @(posedge clk) begin
    section_rpt_t want;
    if (!rst && out_valid && !out_stall) begin
      reports_seen++;
      if (expected_reports.size() == 0) begin
        $error("unexpected report: kind %0d sect_id 0x%0h", kind, sect_id);
        failures++;
      end else begin
        want = expected_reports.pop_front();
        if (!want.kind) sections_seen++;
        check_field("kind", 13'(want.kind), 13'(kind));
        check_field("sect_id", 13'(want.sect_id), 13'(sect_id));
        check_field("section_start", want.start, section_start);
        check_field("sect_len", 13'(want.length), 13'(sect_len));
        check_field("overrun", 13'(want.overrun), 13'(overrun));
        check_field("read_data", 13'(want.read_data), 13'(read_data));
        check_field("last", 13'(want.last), 13'(last));
      end
    end
  end

  // hard stop on a hang
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout with %0d reports outstanding", expected_reports.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    directed_row_t rows[$];
    section_rpt_t  r;
    int            drain;
    ring_base = 0; held = 0; restart_at = 0; consumed = 0;
    packet_reset();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed table
    r = section_rpt(8'h42, 0, 1, 1'b0);
    r.last = 1'b1;
    rows.push_back('{mk(tspsr_pkg::FUNC_BYTE, 8'h00, 1, 0, 1), 0, '{default: '0}});
    rows.push_back('{mk(tspsr_pkg::FUNC_BYTE, 8'h42), 0, '{default: '0}});
    rows.push_back('{mk(tspsr_pkg::FUNC_BYTE, 8'hB0), 0, '{default: '0}});
    rows.push_back('{mk(tspsr_pkg::FUNC_BYTE, 8'h01), 0, '{default: '0}});
    rows.push_back('{mk(tspsr_pkg::FUNC_BYTE, 8'h55, 0, 0, 0, 1), 1, r});
    r = '{kind: 1'b1, sect_id: 8'h00, start: '0, length: '0, overrun: 1'b0,
          read_data: 8'h42, last: 1'b1};
    rows.push_back('{mk(tspsr_pkg::FUNC_READ, 8'h00, 0, 0, 0, 0, 13'd0), 1, r});
    rows.push_back('{mk(FUNC_NONE, 8'hFF, 1, 1, 1, 1, 13'h1FFF), 0, '{default: '0}});
    // oversized adaptation field
    rows.push_back('{mk(tspsr_pkg::FUNC_BYTE, 8'd183, 1, 1, 1), 0, '{default: '0}});
    rows.push_back('{mk(tspsr_pkg::FUNC_BYTE, 8'hAA, 0, 0, 0, 1), 0, '{default: '0}});
    // continuation with nothing open
    rows.push_back('{mk(tspsr_pkg::FUNC_BYTE, 8'h11, 0, 0, 1, 1), 0, '{default: '0}});
    // section followed by a filler jump and a second filler
    rows.push_back('{mk(tspsr_pkg::FUNC_BYTE, 8'h00, 1, 0, 1), 0, '{default: '0}});
    rows.push_back('{mk(tspsr_pkg::FUNC_BYTE, 8'h10), 0, '{default: '0}});
    rows.push_back('{mk(tspsr_pkg::FUNC_BYTE, 8'h00), 0, '{default: '0}});
    rows.push_back('{mk(tspsr_pkg::FUNC_BYTE, 8'h00), 0, '{default: '0}});
    rows.push_back('{mk(tspsr_pkg::FUNC_BYTE, 8'hFF), 0, '{default: '0}});
    rows.push_back('{mk(tspsr_pkg::FUNC_BYTE, 8'hFF, 0, 0, 0, 1), 0, '{default: '0}});
    // pointer past the packet end
    rows.push_back('{mk(tspsr_pkg::FUNC_BYTE, 8'd200, 1, 0, 1, 1), 0, '{default: '0}});
    rows.push_back('{mk(tspsr_pkg::FUNC_CLEAR, 8'h00), 0, '{default: '0}});
    // adaptation field skipped, then a zero-length section
    rows.push_back('{mk(tspsr_pkg::FUNC_BYTE, 8'd2, 0, 1, 1), 0, '{default: '0}});
    rows.push_back('{mk(tspsr_pkg::FUNC_BYTE, 8'h33), 0, '{default: '0}});
    rows.push_back('{mk(tspsr_pkg::FUNC_BYTE, 8'h44), 0, '{default: '0}});
    rows.push_back('{mk(tspsr_pkg::FUNC_BYTE, 8'h00, 1), 0, '{default: '0}});
    rows.push_back('{mk(tspsr_pkg::FUNC_BYTE, 8'h7E), 0, '{default: '0}});
    rows.push_back('{mk(tspsr_pkg::FUNC_BYTE, 8'hF0), 0, '{default: '0}});
    rows.push_back('{mk(tspsr_pkg::FUNC_BYTE, 8'h00, 0, 0, 0, 1), 0, '{default: '0}});
    foreach (rows[i]) send_item(rows[i].stim, rows[i].typed, rows[i].rpt);

    // random traffic under three idling patterns
    run_phase(35, 67, bytes_sent + PHASE_ITEMS);
    run_phase(67, 35, bytes_sent + PHASE_ITEMS);
    run_phase(0, 0, bytes_sent + PHASE_ITEMS);

    // drain outstanding reports, then let the block settle
    drain = 0;
    while (expected_reports.size() != 0 && drain < 200000) begin
      @(posedge clk);
      drain++;
    end
    repeat (400) @(posedge clk);
    if (expected_reports.size() != 0) begin
      $error("%0d expected reports never arrived", expected_reports.size());
      failures++;
    end
    $display("Sent %0d items; checked %0d reports, %0d of them sections.",
             bytes_sent, reports_seen, sections_seen);
    $display("Covered filler jumps, pointer and adaptation handling, reads, clears.");
    if (failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

// ===== ts_psi_section_reassembler.f =====
rtl/tspsr_pkg.sv
rtl/tspsr_ram.sv
rtl/ts_psi_section_reassembler.sv
tb/sv/testbench.sv
